[rtl/dtq_pkg.sv]
// Shared types and constants for the delta timer queue.
package dtq_pkg;

  localparam int TAG_W   = 8;
  localparam int DELTA_W = 32;
  localparam int TPU_W   = 16;
  localparam int TICKS_W = DELTA_W + TPU_W;

  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_CANCEL = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_MAX_DURATION   = 1'b0,
    CFG_TICKS_PER_UNIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SUCC,
    S_SEARCH,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [DELTA_W-1:0] reload_ticks;
    logic               stop_hw;
  } rsp_t;

endpackage

[rtl/dtq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dtq_ctrl.sv]
// Request sequencer: read-modify-write of the timer ring, search and shift.
module dtq_ctrl
  import dtq_pkg::*;
#(
  parameter int QUEUE_CAPACITY = 15,
  parameter int IDX_W = $clog2(QUEUE_CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  logic [TAG_W-1:0]   seq_tag,
  input  logic [DELTA_W-1:0] duration_us,
  input  logic [DELTA_W-1:0] hw_remaining,
  input  logic [DELTA_W-1:0] max_duration_ticks,
  input  logic [TPU_W-1:0]   ticks_per_unit,
  output logic               busy,
  output logic               done,
  output rsp_t               rsp,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output logic [$bits(entry_t)-1:0] ram_wdata,
  output logic [IDX_W-1:0]   ram_raddr,
  input  logic [$bits(entry_t)-1:0] ram_rdata
);

  state_t               state, state_next;
  logic [IDX_W-1:0]     head, head_next;
  logic [IDX_W-1:0]     tail, tail_next;
  logic [IDX_W-1:0]     ptr, ptr_next;
  logic [DELTA_W-1:0]   delta_sum, delta_sum_next;
  logic [DELTA_W-1:0]   rem, rem_next;
  op_t                  op_r, op_r_next;
  logic [TAG_W-1:0]     tag_r, tag_r_next;
  logic [DELTA_W-1:0]   left_r, left_r_next;
  logic [TICKS_W-1:0]   ticks_r, ticks_r_next;
  logic                 done_next;
  rsp_t                 rsp_next;
  entry_t               rd;
  entry_t               wr;
  logic                 empty, full, match;
  logic [DELTA_W-1:0]   add_delta;
  logic [DELTA_W-1:0]   succ_delta;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_CAPACITY)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(QUEUE_CAPACITY) : i - 1'b1;
  endfunction

  assign rd         = entry_t'(ram_rdata);
  assign ram_wdata  = wr;
  assign busy       = (state != S_IDLE);
  assign empty      = (head == tail);
  assign full       = (ring_next(head) == tail);
  assign match      = (rd.tag == tag_r);
  assign add_delta  = ticks_r[DELTA_W-1:0] - left_r - delta_sum;
  assign succ_delta = rd.delta + left_r;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (op_r == OP_CANCEL && !empty) begin
          if (match) begin
            if (ring_next(tail) != head) begin
              state_next = S_SUCC;
            end
          end else if (ring_next(tail) != head) begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SUCC: begin
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (ring_next(ptr) == head) begin
          state_next = S_IDLE;
        end else if (match) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (ring_next(ring_next(ptr)) == head) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    ptr_next       = ptr;
    delta_sum_next = delta_sum;
    rem_next       = rem;
    op_r_next      = op_r;
    tag_r_next     = tag_r;
    left_r_next    = left_r;
    ticks_r_next   = ticks_r;
    done_next      = 1'b0;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = head;
    ram_raddr      = tail;
    wr             = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_r_next    = op_t'(op);
          tag_r_next   = seq_tag;
          left_r_next  = hw_remaining;
          ticks_r_next = TICKS_W'(duration_us) * TICKS_W'(ticks_per_unit);
        end
      end
      S_DECIDE: begin
        if (op_r == OP_ADD) begin
          done_next = 1'b1;
          rsp_next  = '{status: ST_OK, reload_ticks: '0, stop_hw: 1'b0};
          if (full) begin
            rsp_next.status = ST_FULL;
          end else if (ticks_r > TICKS_W'(max_duration_ticks)) begin
            rsp_next.status = ST_TOO_LONG;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head;
            head_next = ring_next(head);
            if (empty) begin
              wr                    = '{tag: tag_r, delta: ticks_r[DELTA_W-1:0]};
              rsp_next.reload_ticks = ticks_r[DELTA_W-1:0];
            end else begin
              wr             = '{tag: tag_r, delta: add_delta};
              delta_sum_next = delta_sum + add_delta;
            end
          end
        end else if (empty) begin
          done_next = 1'b1;
          rsp_next  = '{status: ST_EMPTY, reload_ticks: '0, stop_hw: 1'b0};
        end else if (match) begin
          tail_next = ring_next(tail);
          ram_raddr = ring_next(tail);
          if (ring_next(tail) == head) begin
            done_next = 1'b1;
            rsp_next  = '{status: ST_OK, reload_ticks: '0, stop_hw: 1'b1};
          end
        end else if (ring_next(tail) == head) begin
          done_next = 1'b1;
          rsp_next  = '{status: ST_NOT_FOUND, reload_ticks: '0, stop_hw: 1'b0};
        end else begin
          ram_raddr = ring_next(tail);
          ptr_next  = ring_next(tail);
        end
      end
      S_SUCC: begin
        ram_we         = 1'b1;
        ram_waddr      = tail;
        wr             = '{tag: rd.tag, delta: succ_delta};
        delta_sum_next = delta_sum - rd.delta;
        done_next      = 1'b1;
        rsp_next       = '{status: ST_OK, reload_ticks: succ_delta, stop_hw: 1'b1};
      end
      S_SEARCH: begin
        if (match) begin
          rem_next = rd.delta;
          if (ring_next(ptr) == head) begin
            delta_sum_next = delta_sum - rd.delta;
            head_next      = ring_prev(head);
            done_next      = 1'b1;
            rsp_next       = '{status: ST_OK, reload_ticks: '0, stop_hw: 1'b0};
          end else begin
            ram_raddr = ring_next(ptr);
          end
        end else if (ring_next(ptr) == head) begin
          done_next = 1'b1;
          rsp_next  = '{status: ST_NOT_FOUND, reload_ticks: '0, stop_hw: 1'b0};
        end else begin
          ram_raddr = ring_next(ptr);
          ptr_next  = ring_next(ptr);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        wr        = '{tag: rd.tag, delta: rd.delta + rem};
        rem_next  = '0;
        ptr_next  = ring_next(ptr);
        ram_raddr = ring_next(ring_next(ptr));
        if (ring_next(ring_next(ptr)) == head) begin
          head_next = ring_prev(head);
          done_next = 1'b1;
          rsp_next  = '{status: ST_OK, reload_ticks: '0, stop_hw: 1'b0};
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      delta_sum <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      delta_sum <= delta_sum_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    rem     <= rem_next;
    op_r    <= op_r_next;
    tag_r   <= tag_r_next;
    left_r  <= left_r_next;
    ticks_r <= ticks_r_next;
    rsp     <= rsp_next;
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE))
    else $error("result strobe without a request in progress");

  a_reject_keeps_ring: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> ($stable(head) && $stable(tail)))
    else $error("rejected request changed the ring");

  a_stop_only_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.stop_hw) |-> rsp.status == ST_OK)
    else $error("stop raised on a rejected request");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we) |-> ram_waddr != ram_raddr)
    else $error("shift reads the entry it writes");

endmodule

[rtl/delta_timer_queue_core.sv]
// Delta timer queue: top level with configuration registers and timer ring.
//
// Requests enter on start while busy is low, with op (add or cancel),
// seq_tag, duration_us and hw_remaining. Each request gives exactly one
// result on status, reload_ticks and stop_hw, marked by done for one
// cycle; the receiver cannot stall it, so it must take every result.
// An add is decided in S_DECIDE; a cancel of the running timer passes
// S_DECIDE and, if a later timer follows, S_SUCC; a cancel of a later timer
// passes S_DECIDE, S_SEARCH and, unless it is the newest, S_SHIFT. The ring
// memory port is read once per entry during the search and once per moved
// entry during the shift. A new request may be taken in the cycle done is high.
// Configuration: cfg_we, cfg_addr and cfg_wdata write max_duration_ticks (index 0)
// or ticks_per_unit (index 1); the user must write only while idle, not enforced.
// Reset empties the queue, clears the running sum and restores the
// configuration defaults; ring contents are not cleared.
module delta_timer_queue_core
  import dtq_pkg::*;
#(
  parameter int QUEUE_CAPACITY = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [TAG_W-1:0]   seq_tag,
  input  logic [DELTA_W-1:0] duration_us,
  input  logic [DELTA_W-1:0] hw_remaining,
  output logic               done,
  output logic [2:0]         status,
  output logic [DELTA_W-1:0] reload_ticks,
  output logic               stop_hw,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [DELTA_W-1:0] cfg_wdata
);

  localparam int SLOTS = QUEUE_CAPACITY + 1;
  localparam int IDX_W = $clog2(SLOTS);

  logic [DELTA_W-1:0]        max_duration_ticks;
  logic [TPU_W-1:0]          ticks_per_unit;
  rsp_t                      rsp;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [IDX_W-1:0]          ram_raddr;
  logic [$bits(entry_t)-1:0] ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration_ticks <= '1;
      ticks_per_unit     <= TPU_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_MAX_DURATION:   max_duration_ticks <= cfg_wdata;
        CFG_TICKS_PER_UNIT: ticks_per_unit     <= cfg_wdata[TPU_W-1:0];
        default:            ticks_per_unit     <= ticks_per_unit;
      endcase
    end
  end

  dtq_ctrl #(
    .QUEUE_CAPACITY(QUEUE_CAPACITY),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .op                (op),
    .seq_tag           (seq_tag),
    .duration_us       (duration_us),
    .hw_remaining      (hw_remaining),
    .max_duration_ticks(max_duration_ticks),
    .ticks_per_unit    (ticks_per_unit),
    .busy              (busy),
    .done              (done),
    .rsp               (rsp),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata)
  );

  dtq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign status       = rsp.status;
  assign reload_ticks = rsp.reload_ticks;
  assign stop_hw      = rsp.stop_hw;

endmodule

[tb/tb_delta_timer_queue_core.sv]
// Testbench for delta_timer_queue_core: directed and random timer requests against a predictor.
`timescale 1ns / 1ps

module tb_delta_timer_queue_core;
  import dtq_pkg::*;

  localparam int CAPACITY = 15;
  localparam int SLOTS = CAPACITY + 1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = 1'b0;
  logic [TAG_W-1:0]   seq_tag = '0;
  logic [DELTA_W-1:0] duration_us = '0;
  logic [DELTA_W-1:0] hw_remaining = '0;
  logic               done;
  logic [2:0]         status;
  logic [DELTA_W-1:0] reload_ticks;
  logic               stop_hw;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_addr = '0;
  logic [DELTA_W-1:0] cfg_wdata = '0;

  logic [TAG_W-1:0]   ring_tag [SLOTS];
  logic [DELTA_W-1:0] ring_delta [SLOTS];
  int unsigned        ring_head = 0;
  int unsigned        ring_tail = 0;
  logic [DELTA_W-1:0] pending_sum = '0;
  logic [DELTA_W-1:0] cfg_max_ticks = '1;
  logic [TPU_W-1:0]   cfg_tick_scale = TPU_W'(1);

  rsp_t        expected_timer_rsp [$];
  int unsigned mismatch_count = 0;
  int unsigned gap_pct = 25;

  delta_timer_queue_core #(
    .QUEUE_CAPACITY(CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .seq_tag     (seq_tag),
    .duration_us (duration_us),
    .hw_remaining(hw_remaining),
    .done        (done),
    .status      (status),
    .reload_ticks(reload_ticks),
    .stop_hw     (stop_hw),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1) % SLOTS;
  endfunction

  function automatic int unsigned timers_pending();
    return (ring_head + SLOTS - ring_tail) % SLOTS;
  endfunction

  function automatic rsp_t predict_timer_response(op_t kind, logic [TAG_W-1:0] tag,
                                                  logic [DELTA_W-1:0] dur,
                                                  logic [DELTA_W-1:0] left);
    rsp_t               r;
    logic [TICKS_W-1:0] ticks;
    logic [DELTA_W-1:0] d;
    int unsigned        t;
    int unsigned        i;
    r.status = ST_OK;
    r.reload_ticks = '0;
    r.stop_hw = 1'b0;
    if (kind == OP_ADD) begin
      ticks = TICKS_W'(dur) * TICKS_W'(cfg_tick_scale);
      if (ring_next(ring_head) == ring_tail) begin
        r.status = ST_FULL;
      end else if (ticks > {{TPU_W{1'b0}}, cfg_max_ticks}) begin
        r.status = ST_TOO_LONG;
      end else begin
        ring_tag[ring_head] = tag;
        if (ring_head == ring_tail) begin
          ring_delta[ring_head] = ticks[DELTA_W-1:0];
          r.reload_ticks = ticks[DELTA_W-1:0];
        end else begin
          d = ticks[DELTA_W-1:0] - left - pending_sum;
          ring_delta[ring_head] = d;
          pending_sum = pending_sum + d;
        end
        ring_head = ring_next(ring_head);
      end
    end else if (ring_head == ring_tail) begin
      r.status = ST_EMPTY;
    end else if (ring_tag[ring_tail] == tag) begin
      ring_tail = ring_next(ring_tail);
      r.stop_hw = 1'b1;
      if (ring_tail != ring_head) begin
        pending_sum = pending_sum - ring_delta[ring_tail];
        ring_delta[ring_tail] = ring_delta[ring_tail] + left;
        r.reload_ticks = ring_delta[ring_tail];
      end
    end else begin
      t = ring_next(ring_tail);
      while (t != ring_head && ring_tag[t] != tag) t = ring_next(t);
      if (t == ring_head) begin
        r.status = ST_NOT_FOUND;
      end else begin
        d = ring_delta[t];
        i = t;
        while (ring_next(i) != ring_head) begin
          ring_tag[i] = ring_tag[ring_next(i)];
          ring_delta[i] = ring_delta[ring_next(i)];
          i = ring_next(i);
        end
        ring_head = (ring_head + SLOTS - 1) % SLOTS;
        if (t == ring_head) begin
          pending_sum = pending_sum - d;
        end else begin
          ring_delta[t] = ring_delta[t] + d;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(op_t kind, logic [TAG_W-1:0] tag, logic [DELTA_W-1:0] dur,
                              logic [DELTA_W-1:0] left);
    int unsigned gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= kind;
    seq_tag <= tag;
    duration_us <= dur;
    hw_remaining <= left;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    expected_timer_rsp.push_back(predict_timer_response(kind, tag, dur, left));
  endtask

  task automatic set_timer_config(logic [DELTA_W-1:0] max_ticks, logic [TPU_W-1:0] scale);
    start <= 1'b0;
    while (expected_timer_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MAX_DURATION;
    cfg_wdata <= max_ticks;
    @(posedge clk);
    cfg_max_ticks = max_ticks;
    cfg_addr <= CFG_TICKS_PER_UNIT;
    cfg_wdata <= {16'($urandom()), scale};
    @(posedge clk);
    cfg_tick_scale = scale;
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_request(OP_CANCEL, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_ADD, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_CANCEL, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_fill_and_cancel();
    int i;
    for (i = 1; i <= 14; i++) begin
      send_request(OP_ADD, (i == 7) ? 8'd3 : 8'(i), 32'(i * 1000), $urandom());
    end
    set_timer_config(32'd0, 16'hFFFF);
    send_request(OP_ADD, 8'h55, 32'd1, 32'd0);
    send_request(OP_CANCEL, 8'hAA, 32'd0, 32'd0);
    send_request(OP_CANCEL, 8'd3, 32'd0, 32'd123);
    send_request(OP_CANCEL, 8'd14, 32'd0, 32'd0);
    send_request(OP_CANCEL, 8'hFF, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ADD, 8'h20, 32'd1, 32'd0);
    send_request(OP_ADD, 8'h21, 32'd0, 32'd77);
  endtask

  task automatic test_tick_scaling();
    set_timer_config(32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_ADD, 8'h30, 32'hFFFF_FFFF, 32'd5);
    send_request(OP_ADD, 8'h31, 32'd65537, 32'd9);
  endtask

  task automatic test_random_traffic(int count, bit with_idle);
    int                 n;
    int unsigned        depth;
    int unsigned        lim;
    int unsigned        add_pct;
    bit                 is_add;
    logic [TAG_W-1:0]   tag;
    logic [DELTA_W-1:0] dur;
    logic [DELTA_W-1:0] left;
    add_pct = 50;
    for (n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        add_pct = ($urandom_range(0, 1) != 0) ? 75 : 30;
        gap_pct = (with_idle && $urandom_range(0, 2) != 0) ? 30 : 0;
      end
      depth = timers_pending();
      if (depth == 0) begin
        is_add = $urandom_range(0, 99) < 90;
      end else if (depth == CAPACITY) begin
        is_add = $urandom_range(0, 99) < 25;
      end else begin
        is_add = $urandom_range(0, 99) < add_pct;
      end
      lim = cfg_max_ticks / cfg_tick_scale;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: dur = $urandom_range(0, (lim < 2000) ? lim : 2000);
        4, 5:       dur = $urandom_range(0, lim);
        6:          dur = lim;
        7:          dur = (lim == 32'hFFFF_FFFF) ? $urandom() : lim + 1;
        default:    dur = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0:          left = '0;
        1:          left = '1;
        2, 3, 4:    left = $urandom_range(0, 5000);
        default:    left = $urandom();
      endcase
      if (is_add) begin
        tag = ($urandom_range(0, 4) < 2) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        send_request(OP_ADD, tag, dur, left);
      end else begin
        if (depth != 0 && $urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 99) < 40) begin
            tag = ring_tag[ring_tail];
          end else begin
            tag = ring_tag[(ring_tail + $urandom_range(0, depth - 1)) % SLOTS];
          end
        end else begin
          tag = 8'($urandom_range(0, 255));
        end
        send_request(OP_CANCEL, tag, dur, left);
      end
    end
  endtask

  always @(posedge clk) begin : check_timer_response
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (expected_timer_rsp.size() == 0) begin
        $display("%0t: result with no request pending: status %0d reload %0h stop %0b",
                 $time, status, reload_ticks, stop_hw);
        mismatch_count++;
      end else begin
        want = expected_timer_rsp.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          mismatch_count++;
        end
        if (reload_ticks !== want.reload_ticks) begin
          $display("%0t: reload_ticks expected %0h, got %0h", $time, want.reload_ticks,
                   reload_ticks);
          mismatch_count++;
        end
        if (stop_hw !== want.stop_hw) begin
          $display("%0t: stop_hw expected %0b, got %0b", $time, want.stop_hw, stop_hw);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_and_cancel();
    test_tick_scaling();
    test_random_traffic(150, 1'b1);
    set_timer_config(32'hFFFF_FFFF, 16'd1);
    test_random_traffic(150, 1'b1);
    set_timer_config($urandom(), 16'($urandom_range(1, 65535)));
    test_random_traffic(150, 1'b1);
    set_timer_config(32'd1_000_000, 16'd1000);
    test_random_traffic(150, 1'b1);
    set_timer_config(32'd0, 16'd1);
    test_random_traffic(50, 1'b1);
    set_timer_config(32'hFFFF_FFFF, 16'd2);
    test_random_traffic(250, 1'b0);
    start <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 200 && expected_timer_rsp.size() != 0; wait_cycles++) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (expected_timer_rsp.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_timer_rsp.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
